// ===== src/baro_pressure_temp_compensation_top_assert.svh =====
// Assertion macros used by the barometer compensation top level.
`ifndef BARO_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH
`define BARO_PRESSURE_TEMP_COMPENSATION_TOP_ASSERT_SVH

// Condition that must hold at every clock edge outside reset.
`define BPC_ASSERT_COMB(lbl, cond, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (cond)) else $error(msg);

// Same-cycle implication, checked outside reset.
`define BPC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) else $error(msg);

`endif

// ===== src/bpc_pkg.sv =====
// Types and constants for the barometer compensation pipeline.
package bpc_pkg;

  localparam int D_W       = 24;  // raw conversion width
  localparam int CAL_W     = 16;  // calibration word width
  localparam int CFG_IDX_W = 3;   // config register index width
  localparam int DT_W      = 25;  // dT, signed
  localparam int TEMP1_W   = 19;  // first-order TEMP, signed
  localparam int OFF1_W    = 36;  // first-order OFF, signed
  localparam int SENS1_W   = 36;  // first-order SENS, signed
  localparam int T2_W      = 18;  // T2, unsigned
  localparam int SQ_W      = 36;  // squared temperature offsets, unsigned
  localparam int CORR_W    = 40;  // OFF2 / SENS2, unsigned
  localparam int TEMP2_W   = 20;  // corrected TEMP, signed
  localparam int OFF_W     = 42;  // corrected OFF, signed
  localparam int SENS_W    = 42;  // corrected SENS, signed
  localparam int TC_W      = 15;  // temp_centi width
  localparam int PA_W      = 17;  // pressure_pa width

  localparam int TEMP_REF  = 2000;
  localparam int TEMP_KNEE = -1500;
  localparam int TEMP_LO   = -4000;
  localparam int TEMP_HI   = 8500;
  localparam int PRES_LO   = 1000;
  localparam int PRES_HI   = 120000;

  // Calibration register indexes
  localparam logic [CFG_IDX_W-1:0] CAL_C1 = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CAL_C2 = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CAL_C3 = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CAL_C4 = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CAL_C5 = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CAL_C6 = 3'd5;

  typedef struct packed {
    logic [CAL_W-1:0] c1;
    logic [CAL_W-1:0] c2;
    logic [CAL_W-1:0] c3;
    logic [CAL_W-1:0] c4;
    logic [CAL_W-1:0] c5;
    logic [CAL_W-1:0] c6;
  } cal_t;

  // First-order results
  typedef struct packed {
    logic [D_W-1:0]            d1;
    logic signed [TEMP1_W-1:0] temp1;
    logic signed [OFF1_W-1:0]  off1;
    logic signed [SENS1_W-1:0] sens1;
    logic [T2_W-1:0]           t2;
  } first_t;

  // Second-order corrected terms
  typedef struct packed {
    logic [D_W-1:0]            d1;
    logic signed [TEMP2_W-1:0] temp2;
    logic signed [OFF_W-1:0]   off;
    logic signed [SENS_W-1:0]  sens;
  } comp_t;

endpackage

// ===== src/bpc_first_order.sv =====
// First-order terms: dT, TEMP, OFF, SENS and T2 over three stages.
module bpc_first_order (
  input  logic                  clk,
  input  logic                  rst,
  input  bpc_pkg::cal_t         cal,
  input  logic                  up_valid,
  output logic                  up_ready,
  input  logic [bpc_pkg::D_W-1:0] d1,
  input  logic [bpc_pkg::D_W-1:0] d2,
  output logic                  dn_valid,
  input  logic                  dn_ready,
  output bpc_pkg::first_t       dn_data
);
  import bpc_pkg::*;

  localparam int M_W  = DT_W + CAL_W + 1;  // dT times a calibration word
  localparam int DD_W = 2 * DT_W;          // dT squared

  logic [2:0] vld;
  logic [2:0] adv;

  // stage 1
  logic [D_W-1:0]         d1_s1;
  logic signed [DT_W-1:0] dt_s1;
  // stage 2
  logic [D_W-1:0]         d1_s2;
  logic signed [M_W-1:0]  m_t;
  logic signed [M_W-1:0]  m_off;
  logic signed [M_W-1:0]  m_sens;
  logic signed [DD_W-1:0] m_dd;
  // stage 3
  first_t                 res;

  logic signed [M_W-1:0]  dt_m;
  logic signed [M_W-1:0]  c3_m;
  logic signed [M_W-1:0]  c4_m;
  logic signed [M_W-1:0]  c6_m;
  logic signed [DD_W-1:0] dt_dd;

  assign adv[2]   = !vld[2] || dn_ready;
  assign adv[1]   = !vld[1] || adv[2];
  assign adv[0]   = !vld[0] || adv[1];
  assign up_ready = adv[0];
  assign dn_valid = vld[2];
  assign dn_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= up_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  assign dt_m  = M_W'(dt_s1);
  assign c3_m  = M_W'($signed({1'b0, cal.c3}));
  assign c4_m  = M_W'($signed({1'b0, cal.c4}));
  assign c6_m  = M_W'($signed({1'b0, cal.c6}));
  assign dt_dd = DD_W'(dt_s1);

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      d1_s1 <= d1;
      dt_s1 <= $signed({1'b0, d2}) - $signed({1'b0, cal.c5, 8'h00});
    end
    if (adv[1]) begin
      d1_s2  <= d1_s1;
      m_t    <= dt_m * c6_m;
      m_off  <= dt_m * c4_m;
      m_sens <= dt_m * c3_m;
      m_dd   <= dt_dd * dt_dd;
    end
    if (adv[2]) begin
      res.d1    <= d1_s2;
      res.temp1 <= TEMP1_W'(TEMP_REF) + $signed(m_t[M_W-1:23]);
      res.off1  <= $signed({4'b0, cal.c2, 16'h0000})
                   + OFF1_W'($signed(m_off[M_W-1:7]));
      res.sens1 <= $signed({5'b0, cal.c1, 15'h0000})
                   + SENS1_W'($signed(m_sens[M_W-1:8]));
      res.t2    <= m_dd[T2_W+30:31];  // dT^2 >> 31, never negative
    end
  end

endmodule

// ===== src/bpc_second_order.sv =====
// Second-order correction below 20.00 C and -15.00 C over three stages.
module bpc_second_order (
  input  logic            clk,
  input  logic            rst,
  input  logic            up_valid,
  output logic            up_ready,
  input  bpc_pkg::first_t up_data,
  output logic            dn_valid,
  input  logic            dn_ready,
  output bpc_pkg::comp_t  dn_data
);
  import bpc_pkg::*;

  localparam int SQX_W = 2 * TEMP1_W;

  logic [2:0] vld;
  logic [2:0] adv;

  // stage 4
  first_t                    f_s4;
  logic [SQ_W-1:0]           a_sq;
  logic [SQ_W-1:0]           b_sq;
  logic                      lt_ref;
  logic                      lt_knee;
  // stage 5
  logic [D_W-1:0]            d1_s5;
  logic signed [OFF1_W-1:0]  off1_s5;
  logic signed [SENS1_W-1:0] sens1_s5;
  logic signed [TEMP2_W-1:0] temp2_s5;
  logic [CORR_W-1:0]         off2;
  logic [CORR_W-1:0]         sens2;
  // stage 6
  comp_t                     res;

  logic signed [TEMP1_W-1:0] dm;
  logic signed [TEMP1_W-1:0] dp;
  logic signed [SQX_W-1:0]   dm_x;
  logic signed [SQX_W-1:0]   dp_x;
  logic signed [SQX_W-1:0]   a_full;
  logic signed [SQX_W-1:0]   b_full;
  logic [CORR_W-1:0]         a_w;
  logic [CORR_W-1:0]         b_w;
  logic [CORR_W-1:0]         five_a;
  logic [CORR_W-1:0]         seven_b;
  logic [CORR_W-1:0]         eleven_b;
  logic [CORR_W-1:0]         off2_next;
  logic [CORR_W-1:0]         sens2_next;
  logic signed [TEMP2_W-1:0] t2_sub;

  assign adv[2]   = !vld[2] || dn_ready;
  assign adv[1]   = !vld[1] || adv[2];
  assign adv[0]   = !vld[0] || adv[1];
  assign up_ready = adv[0];
  assign dn_valid = vld[2];
  assign dn_data  = res;

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= up_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
    end
  end

  // squares of TEMP-2000 and TEMP+1500
  assign dm     = up_data.temp1 - TEMP1_W'(TEMP_REF);
  assign dp     = up_data.temp1 - TEMP1_W'(TEMP_KNEE);
  assign dm_x   = SQX_W'(dm);
  assign dp_x   = SQX_W'(dp);
  assign a_full = dm_x * dm_x;
  assign b_full = dp_x * dp_x;

  // constant multiples by shift and add
  assign a_w      = CORR_W'(a_sq);
  assign b_w      = CORR_W'(b_sq);
  assign five_a   = (a_w << 2) + a_w;
  assign seven_b  = (b_w << 3) - b_w;
  assign eleven_b = (b_w << 3) + (b_w << 1) + b_w;

  always_comb begin
    off2_next  = '0;
    sens2_next = '0;
    t2_sub     = '0;
    if (lt_ref) begin
      off2_next  = five_a >> 1;
      sens2_next = five_a >> 2;
      t2_sub     = $signed({2'b00, f_s4.t2});
      if (lt_knee) begin
        off2_next  = (five_a >> 1) + seven_b;
        sens2_next = (five_a >> 2) + (eleven_b >> 1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      f_s4    <= up_data;
      a_sq    <= a_full[SQ_W-1:0];
      b_sq    <= b_full[SQ_W-1:0];
      lt_ref  <= up_data.temp1 < TEMP1_W'(TEMP_REF);
      lt_knee <= up_data.temp1 < TEMP1_W'(TEMP_KNEE);
    end
    if (adv[1]) begin
      d1_s5    <= f_s4.d1;
      off1_s5  <= f_s4.off1;
      sens1_s5 <= f_s4.sens1;
      temp2_s5 <= TEMP2_W'(f_s4.temp1) - t2_sub;
      off2     <= off2_next;
      sens2    <= sens2_next;
    end
    if (adv[2]) begin
      res.d1    <= d1_s5;
      res.temp2 <= temp2_s5;
      res.off   <= OFF_W'(off1_s5) - $signed({2'b00, off2});
      res.sens  <= SENS_W'(sens1_s5) - $signed({2'b00, sens2});
    end
  end

endmodule

// ===== src/bpc_pressure.sv =====
// Pressure product, shifts and output saturation over four stages.
module bpc_pressure (
  input  logic                          clk,
  input  logic                          rst,
  input  logic                          up_valid,
  output logic                          up_ready,
  input  bpc_pkg::comp_t                up_data,
  output logic                          out_valid,
  input  logic                          out_ready,
  output logic signed [bpc_pkg::TC_W-1:0] temp_centi,
  output logic [bpc_pkg::PA_W-1:0]      pressure_pa,
  output logic                          out_of_range
);
  import bpc_pkg::*;

  localparam int SPLIT = 21;                  // D1*SENS is later shifted by 21
  localparam int PL_W  = D_W + SPLIT;         // D1 * SENS[20:0]
  localparam int PH_W  = D_W + 1 + SENS_W - SPLIT;
  localparam int S_W   = PH_W + 1;
  localparam int Q_W   = S_W + 1;
  localparam int P_W   = Q_W - 15;

  logic [3:0] vld;
  logic [3:0] adv;

  // stage 7
  logic [PL_W-1:SPLIT]       pl_hi;
  logic signed [PH_W-1:0]    ph;
  logic signed [OFF_W-1:0]   off_s7;
  logic signed [TEMP2_W-1:0] temp2_s7;
  // stage 8
  logic signed [S_W-1:0]     s_sum;
  logic signed [OFF_W-1:0]   off_s8;
  logic signed [TEMP2_W-1:0] temp2_s8;
  // stage 9
  logic signed [Q_W-1:0]     q_diff;
  logic signed [TEMP2_W-1:0] temp2_s9;

  logic [PL_W-1:0]           pl_full;
  logic signed [PH_W-1:0]    d1_x;
  logic signed [PH_W-1:0]    sh_x;
  logic signed [P_W-1:0]     p_val;
  logic                      p_lo;
  logic                      p_hi;
  logic                      t_lo;
  logic                      t_hi;
  logic signed [TC_W-1:0]    temp_next;
  logic [PA_W-1:0]           pres_next;

  assign adv[3]    = !vld[3] || out_ready;
  assign adv[2]    = !vld[2] || adv[3];
  assign adv[1]    = !vld[1] || adv[2];
  assign adv[0]    = !vld[0] || adv[1];
  assign up_ready  = adv[0];
  assign out_valid = vld[3];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (adv[0]) vld[0] <= up_valid;
      if (adv[1]) vld[1] <= vld[0];
      if (adv[2]) vld[2] <= vld[1];
      if (adv[3]) vld[3] <= vld[2];
    end
  end

  // D1*SENS split at bit 21: (hi*2^21 + lo) >> 21 == hi + (lo >> 21)
  assign pl_full = PL_W'(up_data.d1) * PL_W'(up_data.sens[SPLIT-1:0]);
  assign d1_x    = PH_W'($signed({1'b0, up_data.d1}));
  assign sh_x    = PH_W'($signed(up_data.sens[SENS_W-1:SPLIT]));

  // final shift and clamp
  assign p_val = q_diff[Q_W-1:15];
  assign p_lo  = p_val < P_W'(PRES_LO);
  assign p_hi  = p_val > P_W'(PRES_HI);
  assign t_lo  = temp2_s9 < TEMP2_W'(TEMP_LO);
  assign t_hi  = temp2_s9 > TEMP2_W'(TEMP_HI);

  always_comb begin
    temp_next = temp2_s9[TC_W-1:0];
    if (t_lo) temp_next = TC_W'(TEMP_LO);
    if (t_hi) temp_next = TC_W'(TEMP_HI);
    pres_next = p_val[PA_W-1:0];
    if (p_lo) pres_next = PA_W'(PRES_LO);
    if (p_hi) pres_next = PA_W'(PRES_HI);
  end

  always_ff @(posedge clk) begin
    if (adv[0]) begin
      pl_hi    <= pl_full[PL_W-1:SPLIT];
      ph       <= d1_x * sh_x;
      off_s7   <= up_data.off;
      temp2_s7 <= up_data.temp2;
    end
    if (adv[1]) begin
      s_sum    <= S_W'(ph) + S_W'($signed({1'b0, pl_hi}));
      off_s8   <= off_s7;
      temp2_s8 <= temp2_s7;
    end
    if (adv[2]) begin
      q_diff   <= Q_W'(s_sum) - Q_W'(off_s8);
      temp2_s9 <= temp2_s8;
    end
    if (adv[3]) begin
      temp_centi   <= temp_next;
      pressure_pa  <= pres_next;
      out_of_range <= p_lo || p_hi || t_lo || t_hi;
    end
  end

endmodule

// ===== src/baro_pressure_temp_compensation_top.sv =====
// Top level of the second-order barometer temperature and pressure compensation.

// Compensates one raw pressure/temperature conversion pair per clock with a
// ten-stage pipeline: first-order terms (stages 1-3), second-order correction
// below 20.00 C with an extra term below -15.00 C (stages 4-6), then the
// pressure product, shifts and saturation (stages 7-10). Throughput is one pair
// per cycle while out_ready keeps the output moving, set by the fully pipelined
// multipliers (no stage holds more than one multiply in series, the 24x42
// pressure product split into two partial products). Every stage has its own
// valid bit and moves whenever the stage after it is empty or moving, so bubbles
// are squeezed out and the input keeps taking transfers into empty stages while
// a result waits in the output register. Calibration words C1..C6 sit at config
// indexes 0..5 and reset to zero; writes to other indexes are dropped, and
// writes are only expected while the pipeline is empty. Temperature comes out
// in 0.01 C, clamped to [-4000, 8500]; pressure in Pa, clamped to
// [1000, 120000]; out_of_range flags any clamp.
`include "baro_pressure_temp_compensation_top_assert.svh"

module baro_pressure_temp_compensation_top (
  input  logic                              clk,
  input  logic                              rst,
  // calibration write channel
  input  logic                              cfg_valid,
  output logic                              cfg_ready,
  input  logic [bpc_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [bpc_pkg::CAL_W-1:0]         cfg_data,
  // conversion pair input
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [bpc_pkg::D_W-1:0]           raw_pressure,
  input  logic [bpc_pkg::D_W-1:0]           raw_temperature,
  // compensated result output
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [bpc_pkg::TC_W-1:0]   temp_centi,
  output logic [bpc_pkg::PA_W-1:0]          pressure_pa,
  output logic                              out_of_range
);
  import bpc_pkg::*;

  cal_t   cal;
  logic   first_valid;
  logic   first_ready;
  first_t first_data;
  logic   comp_valid;
  logic   comp_ready;
  comp_t  comp_data;
  logic   temp_ok;
  logic   pres_ok;

  // Calibration registers: always ready, one write per transfer.
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (rst) begin
      cal <= '0;
    end else if (cfg_valid) begin
      case (cfg_index)
        CAL_C1:  cal.c1 <= cfg_data;
        CAL_C2:  cal.c2 <= cfg_data;
        CAL_C3:  cal.c3 <= cfg_data;
        CAL_C4:  cal.c4 <= cfg_data;
        CAL_C5:  cal.c5 <= cfg_data;
        CAL_C6:  cal.c6 <= cfg_data;
        default: ;  // unknown index, write dropped
      endcase
    end
  end

  // Stages 1-3: dT, TEMP, OFF, SENS, T2
  bpc_first_order u_first (
    .clk      (clk),
    .rst      (rst),
    .cal      (cal),
    .up_valid (in_valid),
    .up_ready (in_ready),
    .d1       (raw_pressure),
    .d2       (raw_temperature),
    .dn_valid (first_valid),
    .dn_ready (first_ready),
    .dn_data  (first_data)
  );

  // Stages 4-6: second-order correction
  bpc_second_order u_second (
    .clk      (clk),
    .rst      (rst),
    .up_valid (first_valid),
    .up_ready (first_ready),
    .up_data  (first_data),
    .dn_valid (comp_valid),
    .dn_ready (comp_ready),
    .dn_data  (comp_data)
  );

  // Stages 7-10: pressure and saturation; stage 10 is the output register
  bpc_pressure u_pressure (
    .clk          (clk),
    .rst          (rst),
    .up_valid     (comp_valid),
    .up_ready     (comp_ready),
    .up_data      (comp_data),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .temp_centi   (temp_centi),
    .pressure_pa  (pressure_pa),
    .out_of_range (out_of_range)
  );

  assign temp_ok = (temp_centi >= TC_W'(TEMP_LO)) && (temp_centi <= TC_W'(TEMP_HI));
  assign pres_ok = (pressure_pa >= PA_W'(PRES_LO)) && (pressure_pa <= PA_W'(PRES_HI));

  // Results always land inside the clamp window.
  `BPC_ASSERT_IMP(a_temp_window, out_valid, temp_ok, "temp_centi outside clamp window")
  `BPC_ASSERT_IMP(a_pres_window, out_valid, pres_ok, "pressure_pa outside clamp window")
  // Reset empties the whole pipeline.
  `BPC_ASSERT_IMP(a_reset_empty, $past(rst), !out_valid, "result valid right after reset")
  // With the output register empty, every stage can move, so input is open.
  `BPC_ASSERT_IMP(a_drain_ready, !out_valid, in_ready, "input stalled with empty output")
  `BPC_ASSERT_COMB(a_cfg_open, cfg_ready, "config channel not ready")

endmodule
